// ===== hdl/rpru_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpru_pkg
// Shared types and constants for the probability row update block.
// ----------------------------------------------------------------------------
package rpru_pkg;

    localparam int PROB_W  = 17;
    localparam int COUNT_W = 16;
    localparam int IDX_W   = 6;
    localparam int TOT_W   = 23;
    localparam int SUM_W   = 24;
    localparam logic [PROB_W-1:0] ONE_Q16 = 17'd65536;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_ADJ,
        ST_ADJ_WAIT,
        ST_NORM,
        ST_NORM_WAIT,
        ST_EMIT
    } rpru_state_t;

    typedef struct packed {
        logic clear_row;
        logic store_elem;
        logic clear_ptr;
        logic adj_start;
        logic adj_write;
        logic norm_start;
        logic out_load;
        logic ptr_inc;
    } rpru_cmd_t;

    typedef struct packed {
        logic div_done;
        logic ptr_last;
        logic skip;
        logic sum_zero;
    } rpru_status_t;

endpackage

// ===== hdl/rpru_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpru_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rpru_div #(
    parameter int NUM_W = 41,
    parameter int DEN_W = 24
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quot,
    output logic             done
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [DEN_W:0]   rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;

    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[DEN_W-1:0], quot_reg[NUM_W-1]};
        if (start) begin
            quot_next = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next  = trial - {1'b0, den_reg};
                quot_next = {quot_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next  = trial;
                quot_next = {quot_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign quot = quot_reg;
    assign done = done_reg;

endmodule

// ===== hdl/rpru_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpru_datapath
// Row storage, adjust and normalize arithmetic, output register.
// ----------------------------------------------------------------------------
module rpru_datapath #(
    parameter int MAX_RULES = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [rpru_pkg::PROB_W-1:0]    cfg_wr_data,
    input  logic [rpru_pkg::PROB_W-1:0]    prob_in,
    input  logic                           in_use,
    input  logic [rpru_pkg::COUNT_W-1:0]   use_count,
    input  rpru_pkg::rpru_cmd_t            cmd,
    output rpru_pkg::rpru_status_t         status,
    output logic [rpru_pkg::PROB_W-1:0]    prob_out,
    output logic [rpru_pkg::IDX_W-1:0]     rule_index,
    output logic                           row_done
);
    import rpru_pkg::*;

    localparam int PTR_W = $clog2(MAX_RULES);
    localparam int NUM_W = PROB_W + COUNT_W + 8;

    logic [PROB_W-1:0]  prob_mem [MAX_RULES];
    logic               mask_mem [MAX_RULES];
    logic [COUNT_W-1:0] count_mem [MAX_RULES];

    logic [PROB_W-1:0]  lr_reg;
    logic [PTR_W:0]     n_reg;
    logic [PTR_W-1:0]   ptr_reg;
    logic [TOT_W-1:0]   total_reg;
    logic [PTR_W:0]     masks_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [PROB_W-1:0]  cur_prob;
    logic               cur_mask;
    logic [COUNT_W-1:0] cur_count;
    logic [2*PROB_W-1:0] prod_reg;
    logic [PROB_W+COUNT_W-1:0] lr_count;
    logic [PROB_W-1:0]  newv;
    logic [PROB_W:0]    raised;
    logic [PROB_W:0]    dec;
    logic [NUM_W-1:0]   div_num;
    logic [SUM_W-1:0]   div_den;
    logic [NUM_W-1:0]   quot;
    logic               div_done;
    logic               div_start;
    logic [PROB_W-1:0]  out_prob_reg;
    logic [IDX_W-1:0]   out_idx_reg;
    logic               out_last_reg;
    logic               skip;

    assign skip = (masks_reg <= (PTR_W+1)'(1)) || (total_reg == '0);
    assign cur_prob  = prob_mem[ptr_reg];
    assign cur_mask  = mask_mem[ptr_reg];
    assign cur_count = count_mem[ptr_reg];

    // adjust: used entries divide by total, unused ones shift by 16
    always_ff @(posedge aclk) begin
        if (cmd.adj_start) begin
            prod_reg <= lr_reg * ((cur_count != '0) ? {1'b0, cur_count} : cur_prob);
        end
    end

    assign lr_count  = lr_reg * cur_count;
    assign div_start = cmd.adj_start || cmd.norm_start;
    always_comb begin
        div_num = NUM_W'(lr_count);
        div_den = SUM_W'(total_reg);
        if (cmd.norm_start) begin
            div_num = NUM_W'({cur_prob, 16'd0});
            div_den = sum_reg;
        end
    end

    rpru_div #(.NUM_W(NUM_W), .DEN_W(SUM_W)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(div_num), .den(div_den), .quot(quot), .done(div_done)
    );

    always_comb begin
        newv   = cur_prob;
        raised = {1'b0, cur_prob} + quot[PROB_W:0];
        dec    = prod_reg[2*PROB_W-1:16];
        if (!skip && cur_mask) begin
            if (cur_count != '0) begin
                newv = ((quot[NUM_W-1:PROB_W+1] != '0) || (raised > {1'b0, ONE_Q16}))
                       ? ONE_Q16 : raised[PROB_W-1:0];
            end else begin
                newv = (dec > {1'b0, cur_prob}) ? '0 : cur_prob - dec[PROB_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lr_reg    <= '0;
            n_reg     <= '0;
            ptr_reg   <= '0;
            total_reg <= '0;
            masks_reg <= '0;
            sum_reg   <= '0;
        end else begin
            if (cfg_wr_en) lr_reg <= cfg_wr_data;
            if (cmd.clear_row) begin
                n_reg     <= '0;
                total_reg <= '0;
                masks_reg <= '0;
            end else if (cmd.store_elem && n_reg < (PTR_W+1)'(MAX_RULES)) begin
                n_reg     <= n_reg + 1'b1;
                total_reg <= total_reg + TOT_W'(use_count);
                masks_reg <= masks_reg + (PTR_W+1)'(in_use);
            end
            if (cmd.clear_row) begin
                sum_reg <= '0;
            end else if (cmd.adj_write) begin
                sum_reg <= sum_reg + SUM_W'(newv);
            end
            if (cmd.clear_ptr) begin
                ptr_reg <= '0;
            end else if (cmd.ptr_inc) begin
                ptr_reg <= ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.store_elem && n_reg < (PTR_W+1)'(MAX_RULES)) begin
            prob_mem[n_reg[PTR_W-1:0]]  <= prob_in;
            mask_mem[n_reg[PTR_W-1:0]]  <= in_use;
            count_mem[n_reg[PTR_W-1:0]] <= use_count;
        end else if (cmd.adj_write) begin
            prob_mem[ptr_reg] <= newv;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_prob_reg <= (cmd.norm_start || skip || sum_reg == '0)
                            ? cur_prob : quot[PROB_W-1:0];
            out_idx_reg  <= IDX_W'(ptr_reg);
            out_last_reg <= ((PTR_W+1)'(ptr_reg) + 1'b1) == n_reg;
        end
    end

    assign status.div_done = div_done;
    assign status.ptr_last = ((PTR_W+1)'(ptr_reg) + 1'b1) == n_reg;
    assign status.skip     = skip;
    assign status.sum_zero = (sum_reg == '0);
    assign prob_out   = out_prob_reg;
    assign rule_index = out_idx_reg;
    assign row_done   = out_last_reg;

endmodule

// ===== hdl/rpru_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpru_ctrl
// Sequencer for row load, adjust pass, normalize pass and result hand-off.
// ----------------------------------------------------------------------------
module rpru_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_row_end,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  rpru_pkg::rpru_status_t status,
    output rpru_pkg::rpru_cmd_t    cmd
);
    import rpru_pkg::*;

    rpru_state_t state_reg, state_next;
    logic        skip_reg, skip_next;
    logic        mv_reg, mv_next;
    logic        acc;

    assign acc     = s_valid && s_ready;
    assign s_ready = (state_reg == ST_LOAD);

    always_comb begin
        state_next = state_reg;
        skip_next  = skip_reg;
        mv_next    = mv_reg;
        cmd        = '0;
        if (mv_reg && m_ready) mv_next = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                cmd.store_elem = acc;
                if (acc && s_row_end) begin
                    cmd.clear_ptr = 1'b1;
                    state_next    = ST_ADJ;
                end
            end
            ST_ADJ: begin
                skip_next = status.skip;
                if (status.skip) begin
                    state_next = ST_NORM;
                    cmd.clear_ptr = 1'b0;
                end else begin
                    cmd.adj_start = 1'b1;
                    state_next    = ST_ADJ_WAIT;
                end
            end
            ST_ADJ_WAIT: begin
                if (status.div_done) begin
                    cmd.adj_write = 1'b1;
                    if (status.ptr_last) begin
                        // rewind pointer for the normalize pass, sum is kept
                        cmd.clear_ptr = 1'b1;
                        state_next    = ST_NORM;
                    end else begin
                        cmd.ptr_inc = 1'b1;
                        state_next  = ST_ADJ;
                    end
                end
            end
            ST_NORM: begin
                if (!mv_reg || m_ready) begin
                    if (skip_reg || status.sum_zero) begin
                        cmd.out_load = 1'b1;
                        cmd.norm_start = 1'b1;
                        mv_next = 1'b1;
                        state_next = ST_EMIT;
                    end else begin
                        cmd.norm_start = 1'b1;
                        state_next = ST_NORM_WAIT;
                    end
                end
            end
            ST_NORM_WAIT: begin
                if (status.div_done) begin
                    cmd.out_load = 1'b1;
                    mv_next      = 1'b1;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.ptr_last) begin
                    if (!mv_next) begin
                        cmd.clear_row = 1'b1;
                        cmd.clear_ptr = 1'b1;
                        skip_next  = 1'b0;
                        state_next = ST_LOAD;
                    end
                end else begin
                    cmd.ptr_inc = 1'b1;
                    state_next  = ST_NORM;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            skip_reg  <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            skip_reg  <= skip_next;
            mv_reg    <= mv_next;
        end
    end

    assign m_valid = mv_reg;

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_LOAD) |-> !s_ready)
        else $error("input accepted while row busy");
    a_load_when_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!mv_reg || m_ready))
        else $error("output overwritten");
    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid)
        else $error("result not presented");

endmodule

// ===== hdl/rule_probability_row_update_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rule_probability_row_update_top
// Learning-rate update and normalization of one probability row.
// ----------------------------------------------------------------------------
// Usage: elements of a row enter on the s_ channel, one transaction each, the
// last one with s_row_end set. Elements beyond MAX_RULES are dropped. During
// loading an element is taken every cycle. After row end the input stalls
// while the row is processed: an adjust pass with one 41-step division per
// entry, then a normalize pass with one 41-step division and the result
// hand-off per entry, both on the one shared serial divider. Skipped rows
// emit each element without waiting on the divider. Results leave on the m_
// channel in element order with rule_index and row_done; a stalled receiver
// simply holds the sequencer. Reset empties the row and clears learning_rate.
// learning_rate is written through cfg_wr_en / cfg_wr_data; the user must keep
// such writes to idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module rule_probability_row_update_top #(
    parameter int MAX_RULES = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [rpru_pkg::PROB_W-1:0]  cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [rpru_pkg::PROB_W-1:0]  s_prob_in,
    input  logic                         s_in_use,
    input  logic [rpru_pkg::COUNT_W-1:0] s_use_count,
    input  logic                         s_row_end,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [rpru_pkg::PROB_W-1:0]  m_prob_out,
    output logic [rpru_pkg::IDX_W-1:0]   m_rule_index,
    output logic                         m_row_done
);
    import rpru_pkg::*;

    rpru_cmd_t    cmd;
    rpru_status_t status;

    rpru_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_row_end(s_row_end), .m_valid(m_valid), .m_ready(m_ready),
        .status(status), .cmd(cmd)
    );

    rpru_datapath #(.MAX_RULES(MAX_RULES)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data), .prob_in(s_prob_in), .in_use(s_in_use),
        .use_count(s_use_count), .cmd(cmd), .status(status),
        .prob_out(m_prob_out), .rule_index(m_rule_index), .row_done(m_row_done)
    );

endmodule

// ===== tb/rule_probability_row_update_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rule_probability_row_update_top_test
// Self-checking bench for the probability row update block: a directed table
// of rows, then random rows under several learning rates, with random idling
// on both channels and one long receiver hold-off. Every result is compared
// with a row update predictor kept inside the bench.
// ----------------------------------------------------------------------------
module rule_probability_row_update_top_test;
    import rpru_pkg::*;

    localparam int MAX_ROW   = 16;
    localparam int LIMIT     = 1000000;
    localparam int RAND_ITEMS = 290;
    localparam int SETTLE    = 200;

    typedef struct {
        logic [PROB_W-1:0]  prob;
        logic [IDX_W-1:0]   idx;
        logic               done;
    } row_result_t;

    typedef struct {
        bit                 is_cfg;
        logic [PROB_W-1:0]  prob;
        logic               use_bit;
        logic [COUNT_W-1:0] cnt;
        logic               last;
        bit                 typed;
        logic [PROB_W-1:0]  typed_prob;
    } stim_row_t;

    logic                 aclk = 0;
    logic                 aresetn = 0;
    logic                 cfg_wr_en = 0;
    logic [PROB_W-1:0]    cfg_wr_data = '0;
    logic                 s_valid = 0;
    logic                 s_ready;
    logic [PROB_W-1:0]    s_prob_in = '0;
    logic                 s_in_use = 0;
    logic [COUNT_W-1:0]   s_use_count = '0;
    logic                 s_row_end = 0;
    logic                 m_valid;
    logic                 m_ready = 0;
    logic [PROB_W-1:0]    m_prob_out;
    logic [IDX_W-1:0]     m_rule_index;
    logic                 m_row_done;

    // predictor state
    logic [PROB_W-1:0]    rate_q16 = '0;
    logic [PROB_W-1:0]    row_prob [MAX_ROW];
    logic                 row_mask [MAX_ROW];
    logic [COUNT_W-1:0]   row_cnt [MAX_ROW];
    int unsigned          row_len = 0;
    longint unsigned      cnt_total = 0;
    int unsigned          mask_total = 0;
    bit                   typed_ok [MAX_ROW];
    logic [PROB_W-1:0]    typed_val [MAX_ROW];

    row_result_t          pending_results[$];
    int                   errors = 0;
    int unsigned          cycle_cnt = 0;
    bit                   calm = 0;
    bit                   rand_on = 0;
    bit                   hold_used = 0;
    int                   hold_left = 0;

    rule_probability_row_update_top #(.MAX_RULES(MAX_ROW)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_prob_in(s_prob_in),
        .s_in_use(s_in_use), .s_use_count(s_use_count), .s_row_end(s_row_end),
        .m_valid(m_valid), .m_ready(m_ready), .m_prob_out(m_prob_out),
        .m_rule_index(m_rule_index), .m_row_done(m_row_done)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // row update on one accepted element
    task automatic update_row(input logic [PROB_W-1:0] p, input logic u,
                              input logic [COUNT_W-1:0] c, input logic last);
        longint unsigned newv [MAX_ROW];
        longint unsigned sum;
        longint unsigned v;
        longint unsigned dec;
        bit skip;
        row_result_t r;
        sum = 0;
        if (row_len < MAX_ROW) begin
            row_prob[row_len] = p;
            row_mask[row_len] = u;
            row_cnt[row_len] = c;
            cnt_total += c;
            mask_total += u;
            row_len++;
        end
        if (!last)
            return;
        skip = (mask_total <= 1) || (cnt_total == 0);
        for (int k = 0; k < row_len; k++) begin
            v = row_prob[k];
            if (!skip && row_mask[k]) begin
                if (row_cnt[k] != 0) begin
                    v = v + (longint'(rate_q16) * row_cnt[k]) / cnt_total;
                    if (v > ONE_Q16) v = ONE_Q16;
                end else begin
                    dec = (longint'(rate_q16) * row_prob[k]) >> 16;
                    v = (dec > v) ? 0 : v - dec;
                end
            end
            newv[k] = v;
            sum += v;
        end
        for (int k = 0; k < row_len; k++) begin
            v = newv[k];
            if (!skip && sum > 0)
                v = (v * 65536) / sum;
            r.prob = typed_ok[k] ? typed_val[k] : v[PROB_W-1:0];
            r.idx = k[IDX_W-1:0];
            r.done = (k + 1 == row_len);
            typed_ok[k] = 0;
            pending_results.push_back(r);
        end
        row_len = 0;
        cnt_total = 0;
        mask_total = 0;
    endtask

    task automatic send_elem(input logic [PROB_W-1:0] p, input logic u,
                             input logic [COUNT_W-1:0] c, input logic last);
        while (!calm && $urandom_range(99) < 31) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_prob_in <= p;
        s_in_use <= u;
        s_use_count <= c;
        s_row_end <= last;
        do @(posedge aclk); while (!s_ready);
        update_row(p, u, c, last);
    endtask

    task automatic write_rate(input logic [PROB_W-1:0] val);
        s_valid <= 0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_wr_en <= 1;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 0;
        rate_q16 = val;
    endtask

    function automatic logic [PROB_W-1:0] pick_prob();
        case ($urandom_range(9))
            0: return '0;
            1: return ONE_Q16;
            2: return 17'h1FFFF;
            3: return 17'($urandom_range(255));
            default: return 17'($urandom_range(65536));
        endcase
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count();
        case ($urandom_range(7))
            0, 1: return '0;
            2: return 16'hFFFF;
            3: return 16'($urandom_range(15));
            default: return 16'($urandom);
        endcase
    endfunction

    // result channel: random ready, one long hold-off, checking
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result prob=%0d idx=%0d done=%0d",
                             $time, m_prob_out, m_rule_index, m_row_done);
                    errors++;
                end else begin
                    row_result_t e;
                    e = pending_results.pop_front();
                    if (m_prob_out !== e.prob || m_rule_index !== e.idx ||
                        m_row_done !== e.done) begin
                        $display("%0t: expected prob=%0d idx=%0d done=%0d, got %0d %0d %0d",
                                 $time, e.prob, e.idx, e.done,
                                 m_prob_out, m_rule_index, m_row_done);
                        errors++;
                    end
                end
            end
            if (hold_left > 0) begin
                m_ready <= 0;
                hold_left--;
            end else if (rand_on && !hold_used) begin
                hold_used = 1;
                hold_left = 3000;
                m_ready <= 0;
            end else begin
                m_ready <= calm || ($urandom_range(99) >= 31);
            end
        end
    end

    stim_row_t table_rows[$];

    initial begin
        int n_items;
        int len;
        int row_no;
        stim_row_t t;
        for (int k = 0; k < MAX_ROW; k++) typed_ok[k] = 0;

        // rate 0 after reset: skipped rows come back as loaded
        table_rows = '{
            '{0, ONE_Q16, 1, 16'd5, 1, 1, ONE_Q16},
            '{0, 17'd0, 1, 16'd0, 0, 1, 17'd0},
            '{0, 17'd1234, 1, 16'd0, 1, 1, 17'd1234},
            '{0, 17'h1FFFF, 0, 16'hFFFF, 0, 1, 17'h1FFFF},
            '{0, 17'd300, 1, 16'd7, 1, 1, 17'd300},
            '{0, 17'd40000, 1, 16'd3, 0, 0, 0},
            '{0, 17'd20000, 1, 16'd1, 1, 0, 0},
            '{1, ONE_Q16, 0, 0, 0, 0, 0},
            '{0, 17'd32768, 1, 16'd1, 0, 0, 0},
            '{0, 17'd32768, 1, 16'd0, 0, 0, 0},
            '{0, 17'd0, 0, 16'hFFFF, 0, 0, 0},
            '{0, ONE_Q16, 1, 16'hFFFF, 1, 0, 0},
            '{0, 17'd0, 1, 16'd0, 0, 0, 0},
            '{0, 17'd0, 1, 16'd9, 1, 0, 0},
            '{1, 17'h1FFFF, 0, 0, 0, 0, 0},
            '{0, 17'h1FFFF, 1, 16'd0, 0, 0, 0},
            '{0, 17'd100, 1, 16'd3, 0, 0, 0},
            '{0, 17'd5000, 0, 16'd2, 1, 0, 0},
            '{1, 17'd1, 0, 0, 0, 0, 0},
            '{0, 17'd65535, 1, 16'd2, 0, 0, 0},
            '{0, 17'd1, 1, 16'd0, 1, 0, 0}
        };

        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        foreach (table_rows[i]) begin
            t = table_rows[i];
            if (t.is_cfg) begin
                write_rate(t.prob);
            end else begin
                if (t.typed) begin
                    typed_ok[row_len] = 1;
                    typed_val[row_len] = t.prob;
                end
                send_elem(t.prob, t.use_bit, t.cnt, t.last);
            end
        end

        rand_on = 1;
        n_items = 0;
        row_no = 0;
        while (n_items < RAND_ITEMS) begin
            if (row_no % 12 == 11) begin
                case ($urandom_range(3))
                    0: write_rate('0);
                    1: write_rate(ONE_Q16);
                    2: write_rate(17'($urandom_range(65536)));
                    default: write_rate(17'($urandom_range(4096)));
                endcase
            end
            calm = (n_items > 120 && n_items < 190);
            if ($urandom_range(19) == 0)
                len = $urandom_range(MAX_ROW + 4, MAX_ROW);
            else
                len = $urandom_range(6, 1);
            for (int k = 0; k < len; k++)
                send_elem(pick_prob(), $urandom_range(3) != 0, pick_count(),
                          k == len - 1);
            n_items += len;
            row_no++;
        end
        calm = 0;
        s_valid <= 0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_results.size());
            errors++;
        end
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/rpru_pkg.sv
hdl/rpru_div.sv
hdl/rpru_datapath.sv
hdl/rpru_ctrl.sv
hdl/rule_probability_row_update_top.sv
tb/rule_probability_row_update_top_test.sv
